// ===== rtl/absolute_position_audio_ring_buffer_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the ring buffer
// Sampled on i_clk, muted while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ABSOLUTE_POSITION_AUDIO_RING_BUFFER_TOP_MACROS_SVH
`define ABSOLUTE_POSITION_AUDIO_RING_BUFFER_TOP_MACROS_SVH

// same-cycle implication
`define APARB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APARB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aparb_pkg.sv =====
// ---------------------------------------------------------------------------
// aparb_pkg
// Shared constants, types and codes of the absolute-position ring buffer.
// ---------------------------------------------------------------------------
package aparb_pkg;

    // CAPACITY must be a power of two: pointers wrap by plain overflow
    localparam int CAPACITY      = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int POSITION_BITS = 48;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int COUNT_W       = ADDR_W + 1;
    localparam int AMOUNT_W      = COUNT_W;
    localparam int OP_W          = 3;

    localparam int DATA_BITS     = POSITION_BITS + SAMPLE_BITS + COUNT_W;
    localparam int TDATA_W       = ((DATA_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_WRITE    = 3'd0;
    localparam logic [OP_W-1:0] OP_READ_ABS = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_REL = 3'd2;
    localparam logic [OP_W-1:0] OP_ADVANCE  = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH    = 3'd4;

    typedef logic [POSITION_BITS-1:0]      t_pos;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        t_sample           wdata;
    } t_mem_req;

    typedef struct packed {
        logic               valid;
        logic               rd_ok;
        logic               ok;
        logic [COUNT_W-1:0] fill;
        t_pos               oldest;
    } t_result;

endpackage

// ===== rtl/aparb_ram.sv =====
// ---------------------------------------------------------------------------
// aparb_ram
// Single-port synchronous sample memory with a registered read.
// ---------------------------------------------------------------------------
module aparb_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/aparb_ctrl.sv =====
// ---------------------------------------------------------------------------
// aparb_ctrl
// Sequencer: window pointers, position arithmetic, gap padding, memory access.
// ---------------------------------------------------------------------------
module aparb_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_valid,
    output logic                            o_s_ready,
    input  logic [aparb_pkg::OP_W-1:0]      i_op,
    input  aparb_pkg::t_pos                 i_pos,
    input  aparb_pkg::t_sample              i_smp,
    input  logic [aparb_pkg::AMOUNT_W-1:0]  i_amt,
    input  logic                            i_res_take,
    output aparb_pkg::t_result              o_res,
    output aparb_pkg::t_mem_req             o_mem
);

    import aparb_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_PAD, S_DONE} t_state;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    t_pos                r_pos, n_pos;
    t_sample             r_smp, n_smp;
    logic [AMOUNT_W-1:0] r_amt, n_amt;
    t_pos                r_d, n_d;
    logic                r_ge, n_ge;
    logic [ADDR_W-1:0]   r_wp, n_wp;
    logic [ADDR_W-1:0]   r_rp, n_rp;
    logic [COUNT_W-1:0]  r_held, n_held;
    t_pos                r_oldest, n_oldest;
    logic [COUNT_W-1:0]  r_pad_left, n_pad_left;
    logic [ADDR_W-1:0]   r_pad_addr, n_pad_addr;
    logic                r_ok, n_ok;
    logic                r_rd_ok, n_rd_ok;

    logic                w_accept;
    logic                w_borrow;
    t_pos                w_diff;
    logic                w_d_lt_held;
    logic                w_d_lt_cap;
    logic                w_amt_lt_held;
    logic [ADDR_W-1:0]   w_addr_d;
    t_pos                w_gap;
    logic [COUNT_W-1:0]  w_pads;
    logic [COUNT_W-1:0]  w_adv_n;

    assign o_s_ready = (r_state == S_IDLE) || ((r_state == S_DONE) && i_res_take);
    assign w_accept  = i_s_valid && o_s_ready;

    // offset into the window, taken from the oldest position as it stands at accept
    assign {w_borrow, w_diff} = {1'b0, i_pos} - {1'b0, r_oldest};

    assign w_d_lt_held   = (r_d[POSITION_BITS-1:COUNT_W] == '0)
                           && (r_d[COUNT_W-1:0] < r_held);
    assign w_d_lt_cap    = (r_d[POSITION_BITS-1:ADDR_W] == '0);
    assign w_amt_lt_held = r_amt < r_held;
    assign w_addr_d      = r_rp + r_d[ADDR_W-1:0];
    assign w_gap         = r_d - POSITION_BITS'(r_held);
    assign w_pads        = (|w_gap[POSITION_BITS-1:ADDR_W]) ? COUNT_W'(CAPACITY)
                                                            : w_gap[COUNT_W-1:0];
    assign w_adv_n       = w_amt_lt_held ? r_amt : r_held;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_pos      = r_pos;
        n_smp      = r_smp;
        n_amt      = r_amt;
        n_d        = r_d;
        n_ge       = r_ge;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_held     = r_held;
        n_oldest   = r_oldest;
        n_pad_left = r_pad_left;
        n_pad_addr = r_pad_addr;
        n_ok       = r_ok;
        n_rd_ok    = r_rd_ok;
        o_mem      = '0;

        case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                n_state = S_DONE;
                n_ok    = 1'b0;
                n_rd_ok = 1'b0;
                case (r_op)
                    OP_WRITE: begin
                        if (r_held == '0) begin
                            o_mem.we    = 1'b1;
                            o_mem.addr  = r_wp;
                            o_mem.wdata = r_smp;
                            n_wp        = r_wp + 1'b1;
                            n_held      = COUNT_W'(1);
                            n_oldest    = r_pos;
                            n_ok        = 1'b1;
                        end else if (!r_ge) begin
                            n_ok = 1'b0;
                        end else if (w_d_lt_held) begin
                            o_mem.we    = 1'b1;
                            o_mem.addr  = w_addr_d;
                            o_mem.wdata = r_smp;
                            n_ok        = 1'b1;
                        end else begin
                            // at or past the end: zero-fill the gap first
                            n_pad_left = w_pads;
                            n_pad_addr = r_wp;
                            n_ok       = 1'b1;
                            n_state    = S_PAD;
                        end
                    end
                    OP_READ_ABS: begin
                        o_mem.re = 1'b1;
                        o_mem.addr = w_addr_d;
                        n_rd_ok  = r_ge && w_d_lt_held;
                        n_ok     = r_ge && w_d_lt_held;
                    end
                    OP_READ_REL: begin
                        o_mem.re   = 1'b1;
                        o_mem.addr = r_rp + r_amt[ADDR_W-1:0];
                        n_rd_ok    = w_amt_lt_held;
                        n_ok       = w_amt_lt_held;
                    end
                    OP_ADVANCE: begin
                        n_rp     = r_rp + w_adv_n[ADDR_W-1:0];
                        n_held   = r_held - w_adv_n;
                        n_oldest = r_oldest + POSITION_BITS'(w_adv_n);
                        n_ok     = (r_amt <= r_held);
                    end
                    OP_FLUSH: begin
                        n_wp   = '0;
                        n_rp   = '0;
                        n_held = '0;
                        n_ok   = 1'b1;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            S_PAD: begin
                if (r_pad_left != '0) begin
                    o_mem.we    = 1'b1;
                    o_mem.addr  = r_pad_addr;
                    o_mem.wdata = '0;
                    n_pad_addr  = r_pad_addr + 1'b1;
                    n_pad_left  = r_pad_left - 1'b1;
                end else begin
                    // new sample lands at the end; window then ends at r_pos
                    o_mem.we    = 1'b1;
                    o_mem.addr  = w_addr_d;
                    o_mem.wdata = r_smp;
                    n_wp        = w_addr_d + 1'b1;
                    if (w_d_lt_cap) begin
                        n_held = r_d[COUNT_W-1:0] + 1'b1;
                    end else begin
                        n_held   = COUNT_W'(CAPACITY);
                        n_rp     = w_addr_d + 1'b1;
                        n_oldest = r_pos - POSITION_BITS'(CAPACITY - 1);
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_accept) begin
            n_op    = i_op;
            n_pos   = i_pos;
            n_smp   = i_smp;
            n_amt   = i_amt;
            n_d     = w_diff;
            n_ge    = !w_borrow;
            n_state = S_EXEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_held   <= '0;
            r_oldest <= '0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_held   <= n_held;
            r_oldest <= n_oldest;
        end
        r_op       <= n_op;
        r_pos      <= n_pos;
        r_smp      <= n_smp;
        r_amt      <= n_amt;
        r_d        <= n_d;
        r_ge       <= n_ge;
        r_pad_left <= n_pad_left;
        r_pad_addr <= n_pad_addr;
        r_ok       <= n_ok;
        r_rd_ok    <= n_rd_ok;
    end

    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.rd_ok  = r_rd_ok;
    assign o_res.ok     = r_ok;
    assign o_res.fill   = r_held;
    assign o_res.oldest = r_oldest;

endmodule

// ===== rtl/absolute_position_audio_ring_buffer_top.sv =====
// ---------------------------------------------------------------------------
// absolute_position_audio_ring_buffer_top
// Audio sample ring buffer addressed by absolute sample position.
// ---------------------------------------------------------------------------
//  channel   dir  fields (lsb first)
//  s_axis    in   tdata: position[47:0], sample_value[63:48], amount[74:64]
//                 tuser: operation[2:0]
//  m_axis    out  tdata: sample_out[15:0], fill_level[26:16],
//                 oldest_position[74:27]; tuser: ok[0]
//
//  Each item is accepted and executed, then its result is handed on, as set
//  by the single memory port and its registered read. A write past the end
//  zero-fills the gap first, one zero sample written per cycle, at most 1024.
//  Synchronous active-low reset empties the window; no memory clear pass.
//  The result waits in the output register; a stalled m_axis holds off
//  the next s_axis transfer only once a second result is ready.
// ---------------------------------------------------------------------------
`include "absolute_position_audio_ring_buffer_top_macros.svh"

module absolute_position_audio_ring_buffer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // position, sample_value, amount, zero pad
    input  logic [aparb_pkg::TDATA_W-1:0]   i_s_axis_tdata,
    // operation
    input  logic [aparb_pkg::OP_W-1:0]      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // sample_out, fill_level, oldest_position, zero pad
    output logic [aparb_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    // ok
    output logic [0:0]                      o_m_axis_tuser
);

    import aparb_pkg::*;

    t_result            w_res;
    t_mem_req           w_mem;
    t_sample            w_rdata;
    logic               w_take;

    logic               r_out_valid;
    t_sample            r_out_sample;
    logic               r_out_ok;
    logic [COUNT_W-1:0] r_out_fill;
    t_pos               r_out_oldest;

    aparb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_axis_tvalid),
        .o_s_ready  (o_s_axis_tready),
        .i_op       (i_s_axis_tuser),
        .i_pos      (i_s_axis_tdata[POSITION_BITS-1:0]),
        .i_smp      (i_s_axis_tdata[POSITION_BITS+SAMPLE_BITS-1:POSITION_BITS]),
        .i_amt      (i_s_axis_tdata[DATA_BITS-1:POSITION_BITS+SAMPLE_BITS]),
        .i_res_take (w_take),
        .o_res      (w_res),
        .o_mem      (w_mem)
    );

    aparb_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_re    (w_mem.re),
        .i_addr  (w_mem.addr),
        .i_wdata (w_mem.wdata),
        .o_rdata (w_rdata)
    );

    assign w_take = w_res.valid && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out_sample <= w_res.rd_ok ? w_rdata : '0;
            r_out_ok     <= w_res.ok;
            r_out_fill   <= w_res.fill;
            r_out_oldest <= w_res.oldest;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(TDATA_W-DATA_BITS){1'b0}}, r_out_oldest, r_out_fill,
                              r_out_sample};
    assign o_m_axis_tuser  = r_out_ok;

    `APARB_ASSERT_NOW(a_fill_bound, w_res.valid, w_res.fill <= COUNT_W'(CAPACITY), "fill above capacity")
    `APARB_ASSERT_NOW(a_read_needs_data, w_res.valid && w_res.rd_ok, w_res.fill != '0, "read hit in empty buffer")
    `APARB_ASSERT_NOW(a_no_accept_blocked, w_res.valid && r_out_valid && !i_m_axis_tready, !o_s_axis_tready, "input taken while result blocked")
    `APARB_ASSERT_NEXT(a_take_loads, w_take, r_out_valid, "result lost on load")

endmodule
